// ===== sv/uuid_text_parser_unit_defines.svh =====
// ----------------------------------------------------------------------------
// UUID text parser assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef UUID_TEXT_PARSER_UNIT_DEFINES_SVH
`define UUID_TEXT_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define UUIDP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UUIDP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/uuidp_pkg.sv =====
// ----------------------------------------------------------------------------
// UUID text parser package
// Character classes, parse phases and status codes shared by the parser.
// ----------------------------------------------------------------------------
package uuidp_pkg;

	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_CLOSE = 8'h7D;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	localparam int unsigned NumBytes = 16;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SHORT  = 2'd1,
		ST_DASHES = 2'd2,
		ST_BRACE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_HEX,
		PH_MAYBE_DASH,
		PH_NEED_DASH,
		PH_CLOSE,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic [3:0] nib;
		logic       hex_ok;
		logic       is_open;
		logic       is_dash;
		logic       is_close;
		logic       last;
	} cls_word_t;

endpackage

// ===== sv/uuidp_front.sv =====
// ----------------------------------------------------------------------------
// UUID parser front end
// Accepts characters and classifies them into hex value and delimiter flags.
// ----------------------------------------------------------------------------
module uuidp_front import uuidp_pkg::*; (
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       q_full,
	output logic       push,
	output cls_word_t  word
);

	logic [7:0] c;

	assign c        = s_tdata;
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		word          = '0;
		word.last     = s_tlast;
		word.is_open  = (c == CH_OPEN);
		word.is_dash  = (c == CH_DASH);
		word.is_close = (c == CH_CLOSE);
		priority if (c >= 8'h30 && c <= 8'h39) begin
			word.hex_ok = 1'b1;
			word.nib    = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			word.hex_ok = 1'b1;
			word.nib    = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			word.hex_ok = 1'b1;
			word.nib    = 4'(c - 8'h37);
		end else begin
			word.hex_ok = 1'b0;
			word.nib    = 4'hF;
		end
	end

endmodule

// ===== sv/uuidp_queue.sv =====
// ----------------------------------------------------------------------------
// UUID parser queue
// Short FIFO of classified words between front end and parser.
// ----------------------------------------------------------------------------
`include "uuid_text_parser_unit_defines.svh"

module uuidp_queue import uuidp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_word_t din,
	input  logic      pop,
	output cls_word_t dout,
	output logic      full,
	output logic      empty
);

	cls_word_t        mem [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full  = (count_q == QCntW'(QDepth));
	assign empty = (count_q == '0);
	assign dout  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`UUIDP_ASSERT_NOW(a_q_bound, 1'b1, count_q <= QCntW'(QDepth), "queue overfilled")
	`UUIDP_ASSERT_NOW(a_q_pop_ok, pop, !empty, "pop from empty queue")
	`UUIDP_ASSERT_NEXT(a_q_fill, push && !pop, count_q == $past(count_q) + 1'b1, "count lost a word")

endmodule

// ===== sv/uuidp_back.sv =====
// ----------------------------------------------------------------------------
// UUID parser back end
// Runs the parse state machine over classified words and holds the result.
// ----------------------------------------------------------------------------
`include "uuid_text_parser_unit_defines.svh"

module uuidp_back import uuidp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cls_word_t     w,
	input  logic          q_empty,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [135:0]  m_tdata   // status[1:0], uuid_high[65:2], uuid_low[129:66], zero pad
);

	phase_t      phase_q, phase_d, phase_n;
	logic [4:0]  idx_q, idx_d, idx_inc;
	logic        low_next_q, low_next_d;
	logic        braced_q, braced_d;
	logic        dashes_q, dashes_d;
	status_t     err_q, err_d;
	logic [3:0]  hi_q, hi_d;
	logic [7:0]  bytes_q [NumBytes];
	logic [7:0]  bytes_d [NumBytes];
	logic        take;
	logic        done;
	phase_t      digit_phase;
	status_t     status_d;
	logic [63:0] high_d, low_d;

	logic        out_valid_q;
	status_t     status_q;
	logic [63:0] high_q;
	logic [63:0] low_q;

	assign pop     = !q_empty && (!w.last || !out_valid_q || m_tready);
	assign done    = pop && w.last;
	assign idx_inc = idx_q + 5'd1;

	always_comb begin
		take = 1'b0;
		unique case (phase_q)
			PH_START:      take = !w.is_open;
			PH_HEX:        take = 1'b1;
			PH_MAYBE_DASH: take = !w.is_dash;
			default:       take = 1'b0;
		endcase
		take = take && pop;
	end

	always_comb begin
		priority if (!low_next_q) begin
			digit_phase = PH_HEX;
		end else if (idx_inc[4]) begin
			digit_phase = braced_q ? PH_CLOSE : PH_DONE;
		end else if (idx_inc == 5'd4 && !dashes_q) begin
			digit_phase = PH_MAYBE_DASH;
		end else if (dashes_q && (idx_inc == 5'd6 || idx_inc == 5'd8 || idx_inc == 5'd10)) begin
			digit_phase = PH_NEED_DASH;
		end else begin
			digit_phase = PH_HEX;
		end
	end

	always_comb begin
		phase_d = phase_q;
		if (pop) begin
			unique case (phase_q)
				PH_START:      phase_d = w.is_open ? PH_HEX : digit_phase;
				PH_HEX:        phase_d = digit_phase;
				PH_MAYBE_DASH: phase_d = w.is_dash ? PH_HEX : digit_phase;
				PH_NEED_DASH:  phase_d = w.is_dash ? PH_HEX : PH_ERROR;
				PH_CLOSE:      phase_d = w.is_close ? PH_DONE : PH_ERROR;
				default:       phase_d = phase_q;
			endcase
		end
		phase_n = done ? PH_START : phase_d;
	end

	always_comb begin
		idx_d      = idx_q;
		low_next_d = low_next_q;
		hi_d       = hi_q;
		braced_d   = braced_q;
		dashes_d   = dashes_q;
		err_d      = err_q;
		for (int i = 0; i < NumBytes; i++) begin
			bytes_d[i] = bytes_q[i];
		end
		if (pop) begin
			if (phase_q == PH_START && w.is_open) begin
				braced_d = 1'b1;
			end
			if (phase_q == PH_MAYBE_DASH && w.is_dash) begin
				dashes_d = 1'b1;
			end
			if (phase_q == PH_NEED_DASH && !w.is_dash) begin
				err_d = ST_DASHES;
			end
			if (phase_q == PH_CLOSE && !w.is_close) begin
				err_d = ST_BRACE;
			end
		end
		if (take) begin
			if (!low_next_q) begin
				hi_d       = w.nib;
				low_next_d = 1'b1;
			end else begin
				bytes_d[idx_q[3:0]] = w.hex_ok ? {hi_q, w.nib} : 8'hFF;
				low_next_d          = 1'b0;
				idx_d               = idx_inc;
			end
		end
		unique case (phase_d)
			PH_ERROR: status_d = err_d;
			PH_DONE:  status_d = ST_OK;
			default:  status_d = ST_SHORT;
		endcase
		for (int i = 0; i < 8; i++) begin
			high_d[63-8*i -: 8] = bytes_d[i];
			low_d[63-8*i -: 8]  = bytes_d[i+8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			idx_q      <= '0;
			low_next_q <= 1'b0;
			braced_q   <= 1'b0;
			dashes_q   <= 1'b0;
			err_q      <= ST_OK;
		end else if (done) begin
			phase_q    <= PH_START;
			idx_q      <= '0;
			low_next_q <= 1'b0;
			braced_q   <= 1'b0;
			dashes_q   <= 1'b0;
			err_q      <= ST_OK;
		end else begin
			phase_q    <= phase_n;
			idx_q      <= idx_d;
			low_next_q <= low_next_d;
			braced_q   <= braced_d;
			dashes_q   <= dashes_d;
			err_q      <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		hi_q <= hi_d;
		for (int i = 0; i < NumBytes; i++) begin
			bytes_q[i] <= bytes_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= status_d;
			high_q   <= (status_d == ST_OK) ? high_d : 64'd0;
			low_q    <= (status_d == ST_OK) ? low_d : 64'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, low_q, high_q, status_q};

	`UUIDP_ASSERT_NEXT(a_b_restart, done, phase_q == PH_START && out_valid_q && !low_next_q, "no restart after last word")
	`UUIDP_ASSERT_NOW(a_b_zero_err, out_valid_q && status_q != ST_OK, high_q == '0 && low_q == '0, "value kept on error")
	`UUIDP_ASSERT_NOW(a_b_no_drop, out_valid_q && !m_tready && !q_empty && w.last, !pop, "result overwritten")

endmodule

// ===== sv/uuid_text_parser_unit.sv =====
// ----------------------------------------------------------------------------
// UUID text parser unit
// Parses a UUID text stream, one character a word, into status and value.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                              | tlast
//  s_*     | in        | ch[7:0]                            | last
//  m_*     | out       | status, uuid_high, uuid_low, pad   | -
//
//  One character a cycle sustained while the queue has room.
//  m_tvalid is registered when the parser pops the last character from
//  the queue, unless an earlier result still waits in the output register.
//  A four-word queue separates the classifier from the parser, so input
//  keeps flowing while a result waits; it fills only under output stall.
//  Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module uuid_text_parser_unit import uuidp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // ch[7:0]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata    // status[1:0], uuid_high[65:2], uuid_low[129:66], zero pad
);

	cls_word_t in_word;
	cls_word_t head_word;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;

	uuidp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.word     (in_word)
	);

	uuidp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (in_word),
		.pop    (pop),
		.dout   (head_word),
		.full   (q_full),
		.empty  (q_empty)
	);

	uuidp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.w        (head_word),
		.q_empty  (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== dv/uuid_text_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// UUID text parser unit testbench
// Streams UUID texts one character a word into the parser. Most texts are
// well formed (braced or bare, with or without dashes, mixed case, the odd
// non-hex digit and trailing characters); the rest are broken or random
// noise. A scoreboard follows the parse state for every accepted word and
// checks status and value of each result word in order. Both sides idle
// at random, the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module uuid_text_parser_unit_tb;
	import uuidp_pkg::*;

	localparam int RandItems  = 1230;
	localparam int CycleLimit = 400000;

	typedef struct packed {
		status_t     status;
		logic [63:0] uuid_high;
		logic [63:0] uuid_low;
	} uuid_result_t;

	class uuid_parse_scoreboard;
		phase_t       ph;
		logic [4:0]   byte_idx;
		logic         low_next;
		logic         braced;
		logic         dashed;
		status_t      err;
		logic [63:0]  words [2];
		uuid_result_t expected_uuids [$];
		int           chars_seen;
		int           results_checked;
		int           status_count [4];
		int           failures;

		function new();
			restart();
		endfunction

		function void restart();
			ph       = PH_START;
			byte_idx = '0;
			low_next = 1'b0;
			braced   = 1'b0;
			dashed   = 1'b0;
			err      = ST_OK;
			words[0] = '0;
			words[1] = '0;
		endfunction

		function logic [4:0] digit_value(logic [7:0] c);
			if (c >= "0" && c <= "9") return 5'(c - "0");
			if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
			if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
			return 5'd16;
		endfunction

		function void take_digit(logic [7:0] c);
			logic [4:0] v;
			logic [3:0] idx;
			int         sh;
			v   = digit_value(c);
			idx = byte_idx[3:0];
			sh  = (7 - int'(idx[2:0])) * 8;
			if (!low_next) begin
				words[idx[3]] &= ~(64'hFF << sh);
				words[idx[3]] |= {60'd0, (v[4] ? 4'hF : v[3:0])} << (sh + 4);
				low_next = 1'b1;
				ph       = PH_HEX;
			end else begin
				words[idx[3]] |= (v[4] ? 64'hFF : {60'd0, v[3:0]}) << sh;
				low_next = 1'b0;
				byte_idx = byte_idx + 5'd1;
				if (byte_idx >= 5'd16)
					ph = braced ? PH_CLOSE : PH_DONE;
				else if (byte_idx == 5'd4 && !dashed)
					ph = PH_MAYBE_DASH;
				else if (dashed && (byte_idx == 5'd6 || byte_idx == 5'd8 || byte_idx == 5'd10))
					ph = PH_NEED_DASH;
				else
					ph = PH_HEX;
			end
		endfunction

		function void take_char(logic [7:0] c, logic last);
			uuid_result_t r;
			chars_seen++;
			case (ph)
				PH_START: begin
					if (c == CH_OPEN) begin
						braced = 1'b1;
						ph     = PH_HEX;
					end else take_digit(c);
				end
				PH_HEX: take_digit(c);
				PH_MAYBE_DASH: begin
					if (c == CH_DASH) begin
						dashed = 1'b1;
						ph     = PH_HEX;
					end else take_digit(c);
				end
				PH_NEED_DASH: begin
					if (c == CH_DASH) ph = PH_HEX;
					else begin
						err = ST_DASHES;
						ph  = PH_ERROR;
					end
				end
				PH_CLOSE: begin
					if (c == CH_CLOSE) ph = PH_DONE;
					else begin
						err = ST_BRACE;
						ph  = PH_ERROR;
					end
				end
				default: ;
			endcase
			if (last) begin
				r.status    = (ph == PH_ERROR) ? err : ((ph == PH_DONE) ? ST_OK : ST_SHORT);
				r.uuid_high = (r.status == ST_OK) ? words[0] : 64'd0;
				r.uuid_low  = (r.status == ST_OK) ? words[1] : 64'd0;
				expected_uuids.push_back(r);
				status_count[r.status]++;
				restart();
			end
		endfunction

		function void flag(string what, logic [63:0] exp_v, logic [63:0] got_v);
			failures++;
			if (failures <= 10)
				$display("mismatch on %s in result %0d: expected %h, got %h",
					what, results_checked, exp_v, got_v);
		endfunction

		function void check_result(logic [135:0] d);
			uuid_result_t e;
			if (expected_uuids.size() == 0) begin
				flag("unexpected result word", 64'd0, d[65:2]);
				return;
			end
			e = expected_uuids.pop_front();
			if (d[1:0] !== e.status) flag("status", 64'(e.status), 64'(d[1:0]));
			if (d[65:2] !== e.uuid_high) flag("uuid_high", e.uuid_high, d[65:2]);
			if (d[129:66] !== e.uuid_low) flag("uuid_low", e.uuid_low, d[129:66]);
			if (d[135:130] !== 6'd0) flag("pad", 64'd0, 64'(d[135:130]));
			results_checked++;
		endfunction

		function int outstanding();
			return expected_uuids.size();
		endfunction

		function void close_out();
			while (expected_uuids.size() != 0) begin
				flag("missing result", 64'(expected_uuids[0].status), 64'd0);
				void'(expected_uuids.pop_front());
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;

	uuid_parse_scoreboard sb;
	logic [7:0] text_q [$];
	string      hex_chars = "0123456789abcdefABCDEF";
	int         src_idle_pct;
	int         sink_idle_pct;
	int         hold_request;
	int         hold_left;
	int         sent_items;
	int         cycles;

	uuid_text_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("** uuid_text_parser_unit: FAILED **");
			$finish;
		end
	end

	// receiver: long hold-off on request, random stalls otherwise
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.take_char(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	task automatic send_word(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_items++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], i == s.len() - 1);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_word(text_q[i], i == text_q.size() - 1);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void make_noise_text();
		int n;
		text_q.delete();
		n = $urandom_range(1, 8);
		repeat (n) text_q.push_back(8'($urandom_range(255)));
	endfunction

	function automatic void make_uuid_text();
		bit braced;
		bit dashed;
		int n;
		text_q.delete();
		braced = $urandom_range(1);
		dashed = $urandom_range(1);
		if (braced) text_q.push_back(CH_OPEN);
		for (int i = 0; i < 32; i++) begin
			if (dashed && (i == 8 || i == 12 || i == 16 || i == 20))
				text_q.push_back(CH_DASH);
			if ($urandom_range(24) == 0) text_q.push_back(8'($urandom_range(255)));
			else text_q.push_back(hex_chars[$urandom_range(21)]);
		end
		if (braced) text_q.push_back(CH_CLOSE);
		if ($urandom_range(3) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n) text_q.push_back(8'($urandom_range(255)));
		end
	endfunction

	// damage one spot: cut short, corrupt a separator, drop or insert a character
	function automatic void break_text();
		int marks [$];
		int pos;
		int n;
		case ($urandom_range(3))
			0: begin
				n = $urandom_range(1, text_q.size() - 1);
				while (text_q.size() > n) void'(text_q.pop_back());
			end
			1: begin
				for (int i = 0; i < text_q.size(); i++)
					if (text_q[i] == CH_DASH || text_q[i] == CH_CLOSE) marks.push_back(i);
				pos = (marks.size() != 0) ? marks[$urandom_range(marks.size() - 1)]
					: $urandom_range(text_q.size() - 1);
				text_q[pos] = text_q[pos] ^ 8'($urandom_range(1, 255));
			end
			2: text_q.delete($urandom_range(text_q.size() - 1));
			default: begin
				pos = $urandom_range(text_q.size() - 1);
				text_q.insert(pos, $urandom_range(1) ? CH_DASH : 8'($urandom_range(255)));
			end
		endcase
	endfunction

	task automatic send_random_text();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) make_noise_text();
		else begin
			make_uuid_text();
			if (roll < 40) break_text();
		end
		send_text();
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = 8'd0;
		s_tlast       = 1'b0;
		m_tready      = 1'b0;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_request  = 0;
		hold_left     = 0;
		sent_items    = 0;
		cycles        = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_string("{");
		send_string("{-");
		send_string("0Z");
		send_string("01234567-89abZ");
		wait_for_results();

		for (int p = 0; p < 3; p++) begin
			src_idle_pct  = (p == 0) ? 13 : ((p == 1) ? 65 : 0);
			sink_idle_pct = (p == 0) ? 65 : ((p == 1) ? 13 : 0);
			if (p == 0) begin
				hold_request = 300;
				repeat (8) begin
					make_noise_text();
					send_text();
				end
			end
			while (sent_items < (p + 1) * RandItems / 3)
				send_random_text();
			wait_for_results();
		end

		sb.close_out();
		$display("covered %0d characters and %0d results: %0d ok, %0d short, %0d bad dashes,",
			sb.chars_seen, sb.results_checked, sb.status_count[ST_OK],
			sb.status_count[ST_SHORT], sb.status_count[ST_DASHES]);
		$display("%0d missing brace; %0d failures in %0d cycles",
			sb.status_count[ST_BRACE], sb.failures, cycles);
		if (sb.failures == 0)
			$display("** uuid_text_parser_unit: PASSED **");
		else
			$display("** uuid_text_parser_unit: FAILED **");
		$finish;
	end

endmodule
